// File: sv/dttf_pkg.sv
package dttf_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned VAL_W   = 54;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLEN_W  = 5;
  localparam int unsigned PZ_W    = 7;
  localparam int unsigned FC_W    = 7;
  localparam int unsigned NL_W    = 8;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned EXP_W   = 20;
  localparam int unsigned EV_W    = 24;
  localparam int unsigned P_W     = 22;
  localparam int unsigned K_W     = 4;
  localparam int unsigned PH_W    = 4;

  localparam int unsigned FRACTION_DIGITS = 6;
  localparam int unsigned SIG_MAX_DIGITS  = 16;
  localparam int unsigned P_MAX           = 32;

  localparam logic [PZ_W-1:0]  PZ_MAX    = 7'd127;
  localparam logic [FC_W-1:0]  FC_MAX    = 7'd127;
  localparam logic [EV_W-1:0]  EXP_LIMIT = 24'd1000000;
  localparam logic [VAL_W-1:0] RAW_MAX   = 54'd9000000000000000;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;

  localparam logic [PH_W-1:0] PH_START = 4'd0;
  localparam logic [PH_W-1:0] PH_SIGN  = 4'd1;
  localparam logic [PH_W-1:0] PH_ZERO  = 4'd2;
  localparam logic [PH_W-1:0] PH_INT   = 4'd3;
  localparam logic [PH_W-1:0] PH_DOT   = 4'd4;
  localparam logic [PH_W-1:0] PH_FRAC  = 4'd5;
  localparam logic [PH_W-1:0] PH_EMARK = 4'd6;
  localparam logic [PH_W-1:0] PH_ESIGN = 4'd7;
  localparam logic [PH_W-1:0] PH_EDIG  = 4'd8;
  localparam logic [PH_W-1:0] PH_ERR   = 4'd9;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_GRAMMAR = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_SCALE   = 2'd3;

  // scale by ten to the k: one stage per bit of k, bit 3 split in two
  localparam int unsigned NUM_SCALE = 5;
  localparam logic [1:0] SCALE_BIT [NUM_SCALE] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3};
  localparam logic [VAL_W-1:0] SCALE_MUL [NUM_SCALE] =
    '{54'd10, 54'd100, 54'd10000, 54'd10000, 54'd10000};

  typedef struct packed {
    logic              bad;
    logic              minus;
    logic              nz;
    logic              sat;
    logic [VAL_W-1:0]  sig;
    logic [PZ_W-1:0]   tz;
    logic [LEN_W-1:0]  len;
    logic [FC_W-1:0]   frac_cnt;
    logic [EXP_W-1:0]  exp_mag;
    logic              exp_minus;
  } snap_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  mag;
    logic [K_W-1:0]    k;
    logic              minus;
  } item_t;

endpackage

// File: sv/decimal_text_to_fixed_parser_top.sv
// channel | signals                                   | beat
// --------+-------------------------------------------+--------------------------------
// in      | in_valid_i, in_ready_o, char_code_i,      | one character, last one flagged
//         | last_char_i                               |
// out     | out_valid_o, out_ready_i, status_o,       | one result per flagged string
//         | fixed_value_o                             |
//
// One character is taken per cycle while in_ready_o is high; the string state updates in the cycle it arrives.
// The result of a string reaches the output register through a snapshot stage,
// a check stage and five scale-by-power-of-ten stages.
// Reset clears the string state and all stage valids; no clearing pass is needed.
// A stalled output holds its stage; earlier stages keep filling until the snapshot
// stage is full, and only then in_ready_o drops.
module decimal_text_to_fixed_parser_top
  import dttf_pkg::*;
#(
  parameter int unsigned MAX_CHARS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CHAR_W-1:0]        char_code_i,
  input  logic                     last_char_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [VAL_W-1:0]  fixed_value_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CHARS + 2);

  logic [PH_W-1:0]   phase_q, phase_d;
  logic              minus_q, minus_d;
  logic [VAL_W-1:0]  sig_q, sig_d;
  logic [VAL_W-1:0]  full_q, full_d;
  logic              sat_q, sat_d;
  logic [PZ_W-1:0]   pz_q, pz_d;
  logic [SLEN_W-1:0] slen_q, slen_d;
  logic [FC_W-1:0]   fc_q, fc_d;
  logic [EXP_W-1:0]  exp_q, exp_d;
  logic              emin_q, emin_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              nz_q, nz_d;

  logic              in_acc;
  logic              is_dig, is_emark;
  logic [DIGIT_W-1:0] digit;
  logic              take_sig, take_exp, frac_inc, set_minus, set_esign;
  logic [VAL_W-1:0]  full_x10;
  logic [NL_W-1:0]   nl;
  logic [EV_W-1:0]   ev;
  logic              phase_final;

  snap_t snap_q, snap_d;
  logic  snap_vld_q, snap_rdy;

  item_t                pipe_q [NUM_SCALE+1];
  item_t                pipe_d [NUM_SCALE+1];
  logic [NUM_SCALE:0]   pipe_vld_q, pipe_rdy;

  logic [P_W-1:0]    exp_s, p_val, tzp, lenp;

  logic              out_vld_q, out_rdy;
  logic [STAT_W-1:0] status_q, status_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic              range_bad;

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    is_dig    = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
    is_emark  = (char_code_i == CH_E_LO) || (char_code_i == CH_E_UP);
    digit     = char_code_i[DIGIT_W-1:0];
    take_sig  = 1'b0;
    take_exp  = 1'b0;
    frac_inc  = 1'b0;
    set_minus = 1'b0;
    set_esign = 1'b0;
    phase_d   = PH_ERR;
    unique case (phase_q) inside
      PH_START, PH_SIGN: begin
        if (phase_q == PH_START && char_code_i == CH_MINUS) begin
          set_minus = 1'b1;
          phase_d   = PH_SIGN;
        end else if (char_code_i == CH_ZERO) begin
          phase_d = PH_ZERO;
        end else if (is_dig) begin
          take_sig = 1'b1;
          phase_d  = PH_INT;
        end
      end
      PH_ZERO, PH_INT: begin
        if (phase_q == PH_INT && is_dig) begin
          take_sig = 1'b1;
          phase_d  = PH_INT;
        end else if (char_code_i == CH_DOT) begin
          phase_d = PH_DOT;
        end else if (is_emark) begin
          phase_d = PH_EMARK;
        end
      end
      PH_DOT, PH_FRAC: begin
        if (is_dig) begin
          take_sig = 1'b1;
          frac_inc = 1'b1;
          phase_d  = PH_FRAC;
        end else if (phase_q == PH_FRAC && is_emark) begin
          phase_d = PH_EMARK;
        end
      end
      PH_EMARK: begin
        if (char_code_i == CH_PLUS || char_code_i == CH_MINUS) begin
          set_esign = 1'b1;
          phase_d   = PH_ESIGN;
        end else if (is_dig) begin
          take_exp = 1'b1;
          phase_d  = PH_EDIG;
        end
      end
      PH_ESIGN, PH_EDIG: begin
        if (is_dig) begin
          take_exp = 1'b1;
          phase_d  = PH_EDIG;
        end
      end
      default: phase_d = PH_ERR;
    endcase
  end

  // full_q holds the significand with its pending trailing zeros; it is exact
  // while the digit count stays within the significand limit
  always_comb begin
    minus_d  = minus_q | set_minus;
    emin_d   = set_esign ? (char_code_i == CH_MINUS) : emin_q;
    fc_d     = (frac_inc && fc_q != FC_MAX) ? fc_q + FC_W'(1) : fc_q;
    cnt_d    = (cnt_q <= CNT_W'(MAX_CHARS)) ? cnt_q + CNT_W'(1) : cnt_q;
    full_x10 = (full_q << 3) + (full_q << 1) + VAL_W'(digit);
    nl       = NL_W'(slen_q) + NL_W'(pz_q) + NL_W'(1);
    ev       = (EV_W'(exp_q) << 3) + (EV_W'(exp_q) << 1) + EV_W'(digit);
    exp_d    = exp_q;
    if (take_exp) begin
      exp_d = (ev > EXP_LIMIT) ? EXP_LIMIT[EXP_W-1:0] : ev[EXP_W-1:0];
    end
    nz_d   = nz_q;
    full_d = full_q;
    sig_d  = sig_q;
    slen_d = slen_q;
    sat_d  = sat_q;
    pz_d   = pz_q;
    if (take_sig && (nz_q || digit != '0)) begin
      nz_d   = 1'b1;
      full_d = full_x10;
      if (digit == '0) begin
        pz_d = (pz_q != PZ_MAX) ? pz_q + PZ_W'(1) : pz_q;
      end else begin
        if (!sat_q) begin
          if (nl > NL_W'(SIG_MAX_DIGITS)) begin
            sat_d = 1'b1;
          end else begin
            sig_d  = full_x10;
            slen_d = nl[SLEN_W-1:0];
          end
        end
        pz_d = '0;
      end
    end
    phase_final = (phase_d == PH_ZERO) || (phase_d == PH_INT) ||
                  (phase_d == PH_FRAC) || (phase_d == PH_EDIG);
    snap_d.bad       = (cnt_d > CNT_W'(MAX_CHARS)) || !phase_final;
    snap_d.minus     = minus_d;
    snap_d.nz        = nz_d;
    snap_d.sat       = sat_d;
    snap_d.sig       = sig_d;
    snap_d.tz        = pz_d;
    snap_d.len       = LEN_W'(slen_d) + LEN_W'(pz_d);
    snap_d.frac_cnt  = fc_d;
    snap_d.exp_mag   = exp_d;
    snap_d.exp_minus = emin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      minus_q <= 1'b0;
      sig_q   <= '0;
      full_q  <= '0;
      sat_q   <= 1'b0;
      pz_q    <= '0;
      slen_q  <= '0;
      fc_q    <= '0;
      exp_q   <= '0;
      emin_q  <= 1'b0;
      cnt_q   <= '0;
      nz_q    <= 1'b0;
    end else if (in_acc) begin
      if (last_char_i) begin
        phase_q <= PH_START;
        minus_q <= 1'b0;
        sig_q   <= '0;
        full_q  <= '0;
        sat_q   <= 1'b0;
        pz_q    <= '0;
        slen_q  <= '0;
        fc_q    <= '0;
        exp_q   <= '0;
        emin_q  <= 1'b0;
        cnt_q   <= '0;
        nz_q    <= 1'b0;
      end else begin
        phase_q <= phase_d;
        minus_q <= minus_d;
        sig_q   <= sig_d;
        full_q  <= full_d;
        sat_q   <= sat_d;
        pz_q    <= pz_d;
        slen_q  <= slen_d;
        fc_q    <= fc_d;
        exp_q   <= exp_d;
        emin_q  <= emin_d;
        cnt_q   <= cnt_d;
        nz_q    <= nz_d;
      end
    end
  end

  // check stage: p = exponent - fraction digits + FRACTION_DIGITS, k = tz + p
  always_comb begin
    exp_s = P_W'(snap_q.exp_mag);
    if (snap_q.exp_minus) begin
      exp_s = -exp_s;
    end
    p_val = exp_s - P_W'(snap_q.frac_cnt) + P_W'(FRACTION_DIGITS);
    tzp   = P_W'(snap_q.tz) + p_val;
    lenp  = P_W'(snap_q.len) + p_val;
    pipe_d[0].mag   = snap_q.sig;
    pipe_d[0].minus = snap_q.minus;
    pipe_d[0].k     = tzp[K_W-1:0];
    if (snap_q.bad) begin
      pipe_d[0].status = ST_GRAMMAR;
    end else if (!snap_q.nz) begin
      pipe_d[0].status = snap_q.minus ? ST_GRAMMAR : ST_OK;
    end else if (p_val[P_W-1] && tzp[P_W-1]) begin
      pipe_d[0].status = ST_SCALE;
    end else if (snap_q.sat ||
                 (!p_val[P_W-1] && p_val > P_W'(P_MAX)) ||
                 (!lenp[P_W-1] && lenp > P_W'(SIG_MAX_DIGITS))) begin
      pipe_d[0].status = ST_RANGE;
    end else begin
      pipe_d[0].status = ST_OK;
    end
    for (int i = 0; i < NUM_SCALE; i++) begin
      pipe_d[i+1] = pipe_q[i];
      if (pipe_q[i].k[SCALE_BIT[i]]) begin
        pipe_d[i+1].mag = VAL_W'(pipe_q[i].mag * SCALE_MUL[i]);
      end
    end
  end

  always_comb begin
    range_bad = (pipe_q[NUM_SCALE].status == ST_OK) && (pipe_q[NUM_SCALE].mag > RAW_MAX);
    status_d  = range_bad ? ST_RANGE : pipe_q[NUM_SCALE].status;
    if (status_d != ST_OK) begin
      value_d = '0;
    end else if (pipe_q[NUM_SCALE].minus) begin
      value_d = -pipe_q[NUM_SCALE].mag;
    end else begin
      value_d = pipe_q[NUM_SCALE].mag;
    end
  end

  always_comb begin
    out_rdy             = !out_vld_q || out_ready_i;
    pipe_rdy[NUM_SCALE] = !pipe_vld_q[NUM_SCALE] || out_rdy;
    for (int i = NUM_SCALE - 1; i >= 0; i--) begin
      pipe_rdy[i] = !pipe_vld_q[i] || pipe_rdy[i+1];
    end
    snap_rdy = !snap_vld_q || pipe_rdy[0];
  end

  assign in_ready_o = snap_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
      pipe_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (snap_rdy) begin
        snap_vld_q <= in_acc && last_char_i;
      end
      if (pipe_rdy[0]) begin
        pipe_vld_q[0] <= snap_vld_q;
      end
      for (int i = 0; i < NUM_SCALE; i++) begin
        if (pipe_rdy[i+1]) begin
          pipe_vld_q[i+1] <= pipe_vld_q[i];
        end
      end
      if (out_rdy) begin
        out_vld_q <= pipe_vld_q[NUM_SCALE];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_rdy) begin
      snap_q <= snap_d;
    end
    for (int i = 0; i <= NUM_SCALE; i++) begin
      if (pipe_rdy[i]) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
    if (out_rdy) begin
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign fixed_value_o = $signed(value_q);

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> fixed_value_o == '0)
    else $error("error result carries a nonzero value");

  a_ok_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      ((fixed_value_o[VAL_W-1] ? VAL_W'(-value_q) : value_q) <= RAW_MAX))
    else $error("ok result exceeds the magnitude limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_char_i |=> cnt_q == '0 && phase_q == PH_START && !nz_q)
    else $error("string state not cleared after final character");

  a_snap_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_char_i |=> snap_vld_q)
    else $error("final character did not load the snapshot stage");

  a_sig_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slen_q <= SLEN_W'(SIG_MAX_DIGITS))
    else $error("significand digit count over limit");
`endif

endmodule
